>>> design/qera_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qera_pkg
// Shared constants, types and the ease factor table of the ramp animator.
// ----------------------------------------------------------------------------
package qera_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef logic [15:0][29:0] t_fac_tab;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_REM,
        S_RESOLVE,
        S_DIV,
        S_PROG,
        S_EASE,
        S_LOGN,
        S_LOG,
        S_TMUL,
        S_EXP,
        S_RATIO,
        S_BMUL,
        S_BADD,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_SCHED,
        OP_TICK,
        OP_LOAD,
        OP_REM_MUL,
        OP_RESOLVE,
        OP_DIV_STEP,
        OP_PROG,
        OP_EASE_SEL,
        OP_LOG_NORM,
        OP_LOG_STEP,
        OP_T_MUL,
        OP_EXP_STEP,
        OP_RATIO,
        OP_BLEND_MUL,
        OP_BLEND_ADD,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [3:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic rem_zero;
        logic active;
        logic count_zero;
        logic fits;
        logic ease_special;
    } t_dp_stat;

    function automatic logic [63:0] f_isqrt(logic [63:0] n);
        logic [63:0] n_v;
        logic [63:0] res;
        logic [63:0] bit_v;
        n_v   = n;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (bit_v > n_v) bit_v = bit_v >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (bit_v != 0) begin
                if (n_v >= res + bit_v) begin
                    n_v = n_v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-i) in Q0.30, i = 1..16
    function automatic t_fac_tab f_fac_table();
        t_fac_tab    tab;
        logic [63:0] fac;
        fac = f_isqrt(64'd1 << 59);
        for (int i = 0; i < 16; i++) begin
            tab[i] = fac[29:0];
            fac    = f_isqrt(fac << 30);
        end
        return tab;
    endfunction

    localparam t_fac_tab FAC_TAB = f_fac_table();

endpackage

>>> design/queued_eased_ramp_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queued_eased_ramp_animator
// One animated value channel with a keyframe queue and power-curve easing.
// ----------------------------------------------------------------------------
// Words are taken one at a time: o_ready is high only while the block is idle.
// A schedule word goes straight to the done state, where its result is registered
// once the output register is free. A tick walks the queue: each keyframe segment
// it runs to its end passes the check, remainder and resolve states, and a stop
// inside a segment runs the shared divider (17 steps), the -log2 squaring loop (16
// steps) and the 2^-x product loop (16 steps), each one step a cycle on the single
// datapath. With progress at zero or a zero exponent the two loops are skipped. A
// result waits in the output register while the next word is taken; the block holds
// its next result until that one is read.
module queued_eased_ramp_animator import qera_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic        [31:0] i_delta_time,
    input  logic signed [31:0] i_target_value,
    input  logic        [31:0] i_transition_time,
    input  logic        [23:0] i_ease_exponent,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_current_value,
    output logic               o_animating,
    output logic               o_queue_overflow
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    qera_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    qera_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_delta_time      (i_delta_time),
        .i_target_value    (i_target_value),
        .i_transition_time (i_transition_time),
        .i_ease_exponent   (i_ease_exponent),
        .o_stat            (stat),
        .o_current_value   (o_current_value),
        .o_animating       (o_animating),
        .o_queue_overflow  (o_queue_overflow)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("word accepted while busy");

    a_ovf_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_queue_overflow |-> o_animating)
        else $error("overflow with empty queue");

    a_reset_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
`endif

endmodule

>>> design/qera_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qera_ctrl
// Sequencer: handshakes, segment walk and iteration counts for the datapath.
// ----------------------------------------------------------------------------
module qera_ctrl import qera_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  logic     i_req_type,
    output logic     o_valid,
    input  logic     i_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_valid, n_valid;
    logic       out_load;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = i_req_type ? S_DONE : S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.rem_zero || (!i_stat.active && i_stat.count_zero)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_REM;
                end
            end
            S_REM:     n_state = S_RESOLVE;
            S_RESOLVE: n_state = i_stat.fits ? S_CHECK : S_DIV;
            S_DIV:     if (r_step == 5'd16) n_state = S_PROG;
            S_PROG:    n_state = S_EASE;
            S_EASE:    n_state = i_stat.ease_special ? S_BMUL : S_LOGN;
            S_LOGN:    n_state = S_LOG;
            S_LOG:     if (r_step == 5'd15) n_state = S_TMUL;
            S_TMUL:    n_state = S_EXP;
            S_EXP:     if (r_step == 5'd15) n_state = S_RATIO;
            S_RATIO:   n_state = S_BMUL;
            S_BMUL:    n_state = S_BADD;
            S_BADD:    n_state = S_DONE;
            S_DONE:    if (!r_valid || i_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_step[3:0];
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) o_cmd.op = i_req_type ? OP_SCHED : OP_TICK;
            end
            S_CHECK: begin
                if (!i_stat.rem_zero && !i_stat.active && !i_stat.count_zero) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_REM:     o_cmd.op = OP_REM_MUL;
            S_RESOLVE: o_cmd.op = OP_RESOLVE;
            S_DIV:     o_cmd.op = OP_DIV_STEP;
            S_PROG:    o_cmd.op = OP_PROG;
            S_EASE:    o_cmd.op = OP_EASE_SEL;
            S_LOGN:    o_cmd.op = OP_LOG_NORM;
            S_LOG:     o_cmd.op = OP_LOG_STEP;
            S_TMUL:    o_cmd.op = OP_T_MUL;
            S_EXP:     o_cmd.op = OP_EXP_STEP;
            S_RATIO:   o_cmd.op = OP_RATIO;
            S_BMUL:    o_cmd.op = OP_BLEND_MUL;
            S_BADD:    o_cmd.op = OP_BLEND_ADD;
            S_DONE: begin
                if (!r_valid || i_ready) begin
                    o_cmd.op = OP_OUT;
                    out_load = 1'b1;
                end
            end
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    assign n_step  = (n_state != r_state) ? 5'd0 : r_step + 5'd1;
    assign n_valid = out_load | (r_valid & ~i_ready);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

endmodule

>>> design/qera_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qera_dp
// Datapath: keyframe queue, segment state, divider, log/exp ease and blend.
// ----------------------------------------------------------------------------
module qera_dp import qera_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic        [31:0] i_delta_time,
    input  logic signed [31:0] i_target_value,
    input  logic        [31:0] i_transition_time,
    input  logic        [23:0] i_ease_exponent,
    output t_dp_stat           o_stat,
    output logic signed [31:0] o_current_value,
    output logic               o_animating,
    output logic               o_queue_overflow
);

    logic [31:0] r_q_target   [QUEUE_DEPTH];
    logic [31:0] r_q_duration [QUEUE_DEPTH];
    logic [23:0] r_q_exponent [QUEUE_DEPTH];

    logic [QW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic          r_active;
    logic          r_ovf;
    logic [31:0]   r_start, r_end, r_present, r_len, r_remain;
    logic [23:0]   r_exp;
    logic [16:0]   r_prog;
    logic [48:0]   r_rem_prod;
    logic [31:0]   r_div_rem;
    logic [16:0]   r_div_sh, r_div_q;
    logic [30:0]   r_x;
    logic [15:0]   r_frac;
    logic [4:0]    r_lz;
    logic [15:0]   r_tf;
    logic [12:0]   r_ip;
    logic [30:0]   r_r;
    logic [16:0]   r_ratio;
    logic [32:0]   r_scaled;
    logic          r_neg;

    logic [CW:0]   slot_sum;
    logic [QW-1:0] slot, head_inc;
    logic          full;
    logic [49:0]   rem_sum;
    logic [33:0]   rem_dur;
    logic [32:0]   div_trial;
    logic          div_ge;
    logic [17:0]   prog_sum;
    logic [3:0]    lead;
    logic [61:0]   sq;
    logic [20:0]   nl;
    logic [44:0]   t_prod;
    logic [60:0]   e_prod;
    logic signed [32:0] diff;
    logic [32:0]   mag;
    logic [49:0]   b_prod;

    assign slot_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign slot     = (slot_sum >= (CW+1)'(QUEUE_DEPTH))
                    ? QW'(slot_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(slot_sum);
    assign head_inc = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign full     = (r_count >= CW'(QUEUE_DEPTH));

    assign rem_sum  = {1'b0, r_rem_prod} + 50'd65535;
    assign rem_dur  = rem_sum[49:16];

    assign div_trial = {r_div_rem, r_div_sh[16]};
    assign div_ge    = (div_trial >= {1'b0, r_len});

    assign prog_sum = {1'b0, r_prog} + {1'b0, r_div_q};

    always_comb begin
        lead = '0;
        for (int j = 0; j < 16; j++) begin
            if (r_prog[j]) lead = 4'(j);
        end
    end

    assign sq     = 62'(r_x) * 62'(r_x);
    assign nl     = {r_lz, 16'b0} - {5'b0, r_frac};
    assign t_prod = 45'(nl) * 45'(r_exp);
    assign e_prod = 61'(r_r) * 61'(FAC_TAB[i_cmd.step]);
    assign diff   = $signed({r_end[31], r_end}) - $signed({r_start[31], r_start});
    assign mag    = diff[32] ? 33'(-diff) : 33'(diff);
    assign b_prod = 50'(mag) * 50'(r_ratio);

    assign o_stat.rem_zero     = (r_remain == '0);
    assign o_stat.active       = r_active;
    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.fits         = ({2'b0, r_remain} >= rem_dur);
    assign o_stat.ease_special = (r_exp == '0) || (r_prog == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SCHED && i_transition_time != '0 && !full) begin
            r_q_target[slot]   <= i_target_value;
            r_q_duration[slot] <= i_transition_time;
            r_q_exponent[slot] <= i_ease_exponent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_active  <= 1'b0;
            r_ovf     <= 1'b0;
            r_start   <= '0;
            r_end     <= '0;
            r_present <= '0;
            r_len     <= '0;
            r_exp     <= 24'h010000;
            r_prog    <= ONE_Q16;
            r_remain  <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_SCHED: begin
                    r_ovf <= 1'b0;
                    if (i_transition_time == '0) begin
                        r_count   <= '0;
                        r_active  <= 1'b0;
                        r_present <= i_target_value;
                        r_start   <= i_target_value;
                        r_end     <= i_target_value;
                        r_prog    <= ONE_Q16;
                        r_len     <= '0;
                        r_exp     <= i_ease_exponent;
                    end else if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                        if (!r_active && r_count == '0 && r_prog >= ONE_Q16) begin
                            r_start <= r_present;
                            r_end   <= r_present;
                        end
                    end
                end
                OP_TICK: begin
                    r_ovf    <= 1'b0;
                    r_remain <= i_delta_time;
                end
                OP_LOAD: begin
                    r_start  <= r_present;
                    r_end    <= r_q_target[r_head];
                    r_len    <= (r_q_duration[r_head] != '0) ? r_q_duration[r_head] : 32'd1;
                    r_exp    <= r_q_exponent[r_head];
                    r_prog   <= '0;
                    r_active <= 1'b1;
                    r_head   <= head_inc;
                    r_count  <= r_count - 1'b1;
                end
                OP_REM_MUL: begin
                    r_rem_prod <= 49'(r_len) * 49'(ONE_Q16 - r_prog);
                end
                OP_RESOLVE: begin
                    if ({2'b0, r_remain} >= rem_dur) begin
                        r_prog    <= ONE_Q16;
                        r_present <= r_end;
                        r_active  <= 1'b0;
                        r_remain  <= r_remain - rem_dur[31:0];
                    end else begin
                        r_div_rem <= {1'b0, r_remain[31:1]};
                        r_div_sh  <= {r_remain[0], 16'b0};
                        r_div_q   <= '0;
                        r_remain  <= '0;
                    end
                end
                OP_DIV_STEP: begin
                    r_div_rem <= div_ge ? 32'(div_trial - {1'b0, r_len}) : div_trial[31:0];
                    r_div_q   <= {r_div_q[15:0], div_ge};
                    r_div_sh  <= {r_div_sh[15:0], 1'b0};
                end
                OP_PROG: begin
                    r_prog <= (prog_sum > 18'(ONE_Q16)) ? ONE_Q16 : prog_sum[16:0];
                end
                OP_EASE_SEL: begin
                    r_ratio <= (r_exp == '0) ? ONE_Q16 : '0;
                end
                OP_LOG_NORM: begin
                    r_x    <= 31'(r_prog[15:0]) << (5'd30 - {1'b0, lead});
                    r_lz   <= 5'd16 - {1'b0, lead};
                    r_frac <= '0;
                end
                OP_LOG_STEP: begin
                    r_x    <= sq[61] ? sq[61:31] : sq[60:30];
                    r_frac <= {r_frac[14:0], sq[61]};
                end
                OP_T_MUL: begin
                    r_tf <= t_prod[31:16];
                    r_ip <= t_prod[44:32];
                    r_r  <= 31'h4000_0000;
                end
                OP_EXP_STEP: begin
                    if (r_tf[15]) r_r <= e_prod[60:30];
                    r_tf <= {r_tf[14:0], 1'b0};
                end
                OP_RATIO: begin
                    r_ratio <= (r_ip > 13'd16) ? '0 : 17'(r_r >> (5'd14 + r_ip[4:0]));
                end
                OP_BLEND_MUL: begin
                    r_scaled <= b_prod[48:16];
                    r_neg    <= diff[32];
                end
                OP_BLEND_ADD: begin
                    r_present <= r_neg ? r_start - r_scaled[31:0] : r_start + r_scaled[31:0];
                end
                OP_OUT: begin
                    o_current_value  <= r_present;
                    o_animating      <= r_active || (r_count != '0);
                    o_queue_overflow <= r_ovf;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> test/queued_eased_ramp_animator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queued_eased_ramp_animator_tb
// Drives schedule and tick words with random gaps on both handshakes and
// compares every result word with a bit-exact model of the keyframe queue.
// ----------------------------------------------------------------------------
module queued_eased_ramp_animator_tb;
    import qera_pkg::*;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_SCHED = 1'b1;
    localparam int   LIMIT     = 2_000_000;
    localparam int   EXP_DEPTH = 1024;

    typedef struct packed {
        logic        rt;
        logic [31:0] dt;
        logic [31:0] tv;
        logic [31:0] tt;
        logic [23:0] ex;
        logic        known;
        logic [31:0] k_val;
        logic        k_anim;
        logic        k_ovf;
    } t_row;

    typedef struct packed {
        logic [31:0] val;
        logic        anim;
        logic        ovf;
    } t_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_req_type = 1'b0;
    logic        [31:0] i_delta_time = '0;
    logic signed [31:0] i_target_value = '0;
    logic        [31:0] i_transition_time = '0;
    logic        [23:0] i_ease_exponent = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_current_value;
    logic               o_animating;
    logic               o_queue_overflow;

    queued_eased_ramp_animator i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic [31:0] q_tgt [QUEUE_DEPTH];
    logic [31:0] q_dur [QUEUE_DEPTH];
    logic [31:0] q_exp [QUEUE_DEPTH];
    int unsigned q_head, q_cnt;
    bit          seg_on;
    logic [31:0] lvl_start, lvl_end, lvl_now, seg_len, seg_exp, prog;

    // expected results, in order
    t_res        exp_mem [EXP_DEPTH];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;
    int    errors = 0;
    int    cycles = 0;
    bit    hold_off = 1'b0;

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] nlog2(logic [31:0] p);
        int          k;
        logic [63:0] x, fr;
        k  = 15;
        fr = 0;
        while (k > 0 && p[k] == 1'b0) k--;
        x = 64'(p) << (30 - k);
        for (int i = 1; i <= 16; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x  = x >> 1;
                fr = fr | (64'd1 << (16 - i));
            end
        end
        return (64'(16 - k) << 16) - fr;
    endfunction

    function automatic logic [31:0] ease(logic [31:0] p, logic [31:0] e);
        logic [63:0] t, r, f, ip;
        if (p >= 32'h10000) return 32'h10000;
        if (e == 0) return 32'h10000;
        if (p == 0) return 0;
        t  = (nlog2(p) * e) >> 16;
        ip = t >> 16;
        if (ip > 16) return 0;
        r = 64'd1 << 30;
        f = root64(64'd1 << 59);
        for (int i = 1; i <= 16; i++) begin
            if (t[16 - i]) r = (r * f) >> 30;
            f = root64(f << 30);
        end
        return 32'(r >> (14 + ip));
    endfunction

    function automatic logic [31:0] blend(logic [31:0] s, logic [31:0] d, logic [31:0] ra);
        longint a, df, v;
        logic [63:0] mag, sc;
        a   = longint'($signed(s));
        df  = longint'($signed(d)) - a;
        mag = df < 0 ? -df : df;
        sc  = (mag * ra) >> 16;
        v   = df < 0 ? a - longint'(sc) : a + longint'(sc);
        return v[31:0];
    endfunction

    task automatic advance_time(logic [63:0] left);
        logic [63:0] rd, use_t, np;
        while (left > 0) begin
            if (!seg_on) begin
                if (q_cnt == 0) return;
                lvl_start = lvl_now;
                lvl_end   = q_tgt[q_head];
                seg_len   = q_dur[q_head] != 0 ? q_dur[q_head] : 1;
                seg_exp   = q_exp[q_head];
                prog      = 0;
                seg_on    = 1;
                q_head    = (q_head + 1) % QUEUE_DEPTH;
                q_cnt--;
            end
            if (seg_len == 0) seg_len = 1;
            if (prog > 32'h10000) prog = 32'h10000;
            rd    = (64'(seg_len) * (64'h10000 - prog) + 64'hFFFF) >> 16;
            use_t = left < rd ? left : rd;
            if (use_t == rd) begin
                prog = 32'h10000;
            end else begin
                np   = prog + ((use_t << 16) / seg_len);
                prog = np > 64'h10000 ? 32'h10000 : np[31:0];
            end
            lvl_now = blend(lvl_start, lvl_end, ease(prog, seg_exp));
            left    = left - use_t;
            if (prog >= 32'h10000) begin
                lvl_now = lvl_end;
                seg_on  = 0;
            end
            if (use_t == 0) break;
        end
    endtask

    task automatic predict_word(t_row w);
        t_res r;
        int unsigned slot;
        r.ovf = 0;
        if (w.rt == REQ_TICK) begin
            advance_time(64'(w.dt));
        end else if (w.tt == 0) begin
            q_cnt = 0;
            seg_on = 0;
            lvl_now = w.tv;
            lvl_start = w.tv;
            lvl_end = w.tv;
            prog = 32'h10000;
            seg_len = 0;
            seg_exp = 32'(w.ex);
        end else if (q_cnt >= QUEUE_DEPTH) begin
            r.ovf = 1;
        end else begin
            slot = (q_head + q_cnt) % QUEUE_DEPTH;
            q_tgt[slot] = w.tv;
            q_dur[slot] = w.tt;
            q_exp[slot] = 32'(w.ex);
            q_cnt++;
            if (!seg_on && q_cnt == 1 && prog >= 32'h10000) begin
                lvl_start = lvl_now;
                lvl_end = lvl_now;
            end
        end
        r.val  = lvl_now;
        r.anim = seg_on || q_cnt != 0;
        if (w.known && r != {w.k_val, w.k_anim, w.k_ovf}) begin
            $error("table row disagrees: exp %h/%0b/%0b", w.k_val, w.k_anim, w.k_ovf);
            errors++;
        end
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    function automatic int gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    task automatic send_word(t_row w);
        i_valid           <= 1'b1;
        i_req_type        <= w.rt;
        i_delta_time      <= w.dt;
        i_target_value    <= w.tv;
        i_transition_time <= w.tt;
        i_ease_exponent   <= w.ex;
        predict_word(w);
        do @(posedge i_clk); while (!o_ready);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_row rnd_word();
        t_row w;
        w       = '0;
        w.rt    = 1'($urandom_range(0, 1));
        w.tv    = $urandom;
        w.ex    = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4 << 16));
        w.tt    = ($urandom_range(0, 15) == 0) ? 0 :
                  ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 20 << 16);
        w.dt    = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 8 << 16);
        return w;
    endfunction

    // receiver
    initial begin
        int g;
        t_res e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (exp_wr == exp_rd) begin
                    $error("result word with none expected");
                    errors++;
                end else begin
                    e = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (o_current_value !== e.val) begin
                        $error("current_value exp %h got %h", e.val, o_current_value);
                        errors++;
                    end
                    if (o_animating !== e.anim) begin
                        $error("animating exp %0b got %0b", e.anim, o_animating);
                        errors++;
                    end
                    if (o_queue_overflow !== e.ovf) begin
                        $error("queue_overflow exp %0b got %0b", e.ovf, o_queue_overflow);
                        errors++;
                    end
                end
            end
            if (hold_off) begin
                i_ready <= 1'b0;
                for (g = 0; g < 2000; g++) @(posedge i_clk);
                hold_off = 1'b0;
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 20);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    t_row dir_tab[] = '{
        '{REQ_TICK,  32'd0,  32'h0,         32'h0,         24'h0,      1, 32'h0, 0, 0},
        '{REQ_TICK,  32'hFFFF_FFFF, 32'h0,  32'h0,         24'h0,      1, 32'h0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h7FFF_FFFF, 32'h0,         24'hFF_FFFF, 1, 32'h7FFF_FFFF, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h8000_0000, 32'h0,         24'h01_0000, 1, 32'h8000_0000, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h7FFF_FFFF, 32'h4_0000,    24'h01_0000, 0, 0, 0, 0},
        '{REQ_TICK,  32'h1_0000, 32'h0,     32'h0,         24'h0,      0, 0, 0, 0},
        '{REQ_TICK,  32'h0,  32'h0,         32'h0,         24'h0,      0, 0, 0, 0},
        '{REQ_TICK,  32'h8000, 32'h0,       32'h0,         24'h0,      0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h0,         32'h1,         24'h0,      0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h1234_0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'hFFFF_0000, 32'h2_0000,    24'h0,      0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h5_0000,    32'h3_0000,    24'h02_0000, 0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h6_0000,    32'h3_0000,    24'h00_8000, 0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h7_0000,    32'h3_0000,    24'h10_0000, 0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h8_0000,    32'h3_0000,    24'h01_0000, 0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h9_0000,    32'h3_0000,    24'h01_0000, 0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'hA_0000,    32'h3_0000,    24'h01_0000, 0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'hB_0000,    32'h3_0000,    24'h01_0000, 0, 0, 0, 1},
        '{REQ_TICK,  32'h1_8000, 32'h0,     32'h0,         24'h0,      0, 0, 0, 0},
        '{REQ_TICK,  32'hFFFF_FFFF, 32'h0,  32'h0,         24'h0,      0, 0, 0, 0},
        '{REQ_TICK,  32'h1,  32'h0,         32'h0,         24'h0,      0, 0, 0, 0},
        '{REQ_SCHED, 32'd0,  32'h0,         32'h0,         24'h0,      1, 32'h0, 0, 0}
    };

    initial begin
        int g;
        t_row w;
        q_head = 0; q_cnt = 0; seg_on = 0;
        lvl_start = 0; lvl_end = 0; lvl_now = 0; seg_len = 0;
        seg_exp = 32'h10000; prog = 32'h10000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tab[n]) begin
            send_word(dir_tab[n]);
            for (g = gap(); g > 0; g--) @(posedge i_clk);
        end
        for (int n = 0; n < 750; n++) begin
            if (n == 100) hold_off = 1'b1;
            if (n == 400) begin
                while (exp_wr != exp_rd) @(posedge i_clk);
            end
            w = rnd_word();
            if (n >= 300 && n < 400) w.rt = REQ_SCHED;
            send_word(w);
            if (!(n >= 100 && n < 140) && !(n >= 200 && n < 260))
                for (g = gap(); g > 0; g--) @(posedge i_clk);
        end
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
design/qera_pkg.sv
design/qera_ctrl.sv
design/qera_dp.sv
design/queued_eased_ramp_animator.sv
test/queued_eased_ramp_animator_tb.sv
